/* hw/rtl/srld_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite RLE line decoder package
// Shared constants, codes and the result record of the sprite row decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

    // Width of the frame pixel counter; the counter saturates at its top value.
    localparam int PIXEL_ADDR_BITS = 20;
    localparam logic [PIXEL_ADDR_BITS-1:0] POS_LIMIT = '1;

    localparam int WORD_W   = 16;
    localparam int POS_W    = 20;
    localparam int RUN_W    = 15;
    localparam int HEIGHT_W = 16;

    // Tag word layout: bit 0 marks a literal run, the upper bits hold the length.
    localparam logic [WORD_W-1:0] TAG_LITERAL_BIT = 16'h0001;
    localparam logic [WORD_W-1:0] TAG_LEN_MASK    = 16'hFFFE;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_FILL    = 2'd1,
        KIND_ROW_END = 2'd2
    } kind_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  position;
        logic [RUN_W-1:0]  run_length;
        logic [WORD_W-1:0] pixel_value;
        logic              frame_done;
        logic              overflow;
    } result_t;

endpackage

/* hw/rtl/srld_in_stage.sv */
// ----------------------------------------------------------------------------
// Sprite RLE input stage
// Registers one incoming data word and hands it to the decode logic.
// ----------------------------------------------------------------------------
module srld_in_stage
    import srld_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,
    input  logic              take,
    output in_item_t          item
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] word_reg;

    // A new word may enter whenever the held one leaves in the same cycle.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (valid_reg && !take) || (s_tvalid && s_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            word_reg <= s_tdata;
        end
    end

    assign item.valid = valid_reg;
    assign item.word  = word_reg;

endmodule

/* hw/rtl/srld_core.sv */
// ----------------------------------------------------------------------------
// Sprite RLE decode core
// Holds the row state and turns one data word into at most one result.
// ----------------------------------------------------------------------------
module srld_core
    import srld_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [HEIGHT_W-1:0] cfg_wr_data,
    input  in_item_t            item,
    input  logic                out_ready,
    output logic                take,
    output logic                res_valid,
    output result_t             res
);

    localparam int SUM_W = ((PIXEL_ADDR_BITS > RUN_W) ? PIXEL_ADDR_BITS : RUN_W) + 1;

    logic [HEIGHT_W-1:0]        height_reg;
    logic [RUN_W-1:0]           lit_left_reg;
    logic [RUN_W-1:0]           lit_left_next;
    logic [PIXEL_ADDR_BITS-1:0] pos_reg;
    logic [PIXEL_ADDR_BITS-1:0] pos_next;
    logic [HEIGHT_W-1:0]        rows_reg;
    logic [HEIGHT_W-1:0]        rows_next;

    logic [RUN_W-1:0]           tag_len;
    logic [RUN_W-1:0]           adv_len;
    logic [SUM_W-1:0]           pos_sum;
    logic                       sat;
    logic [PIXEL_ADDR_BITS-1:0] pos_adv;
    logic [HEIGHT_W:0]          rows_inc;
    logic                       done;
    logic                       is_literal;

    assign take       = item.valid && out_ready;
    assign is_literal = (lit_left_reg != '0);
    assign tag_len    = RUN_W'((item.word & TAG_LEN_MASK) >> 1);
    assign adv_len    = is_literal ? RUN_W'(1) : tag_len;

    // Saturating advance of the pixel counter.
    assign pos_sum = SUM_W'(pos_reg) + SUM_W'(adv_len);
    assign sat     = pos_sum > SUM_W'(POS_LIMIT);
    assign pos_adv = sat ? POS_LIMIT : PIXEL_ADDR_BITS'(pos_sum);

    // A height of zero, or one lowered below the rows seen, closes at once.
    assign rows_inc = {1'b0, rows_reg} + (HEIGHT_W+1)'(1);
    assign done     = rows_inc >= {1'b0, height_reg};

    always_comb begin
        lit_left_next   = lit_left_reg;
        pos_next        = pos_reg;
        rows_next       = rows_reg;
        res_valid       = 1'b0;
        res.kind        = KIND_LITERAL;
        res.position    = POS_W'(pos_reg);
        res.run_length  = '0;
        res.pixel_value = '0;
        res.frame_done  = 1'b0;
        res.overflow    = 1'b0;
        if (is_literal) begin
            lit_left_next   = lit_left_reg - RUN_W'(1);
            pos_next        = pos_adv;
            res_valid       = take;
            res.pixel_value = item.word;
            res.overflow    = sat;
        end else if (item.word == '0) begin
            res_valid      = take;
            res.kind       = KIND_ROW_END;
            res.frame_done = done;
            if (done) begin
                rows_next = '0;
                pos_next  = '0;
            end else begin
                rows_next = HEIGHT_W'(rows_inc);
            end
        end else if ((item.word & TAG_LITERAL_BIT) != '0) begin
            lit_left_next = tag_len;
        end else begin
            pos_next       = pos_adv;
            res_valid      = take;
            res.kind       = KIND_FILL;
            res.run_length = tag_len;
            res.overflow   = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg   <= HEIGHT_W'(1);
            lit_left_reg <= '0;
            pos_reg      <= '0;
            rows_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                height_reg <= cfg_wr_data;
            end
            if (take) begin
                lit_left_reg <= lit_left_next;
                pos_reg      <= pos_next;
                rows_reg     <= rows_next;
            end
        end
    end

    // A literal word always uses up exactly one slot of the pending run.
    a_lit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        take && is_literal |=> lit_left_reg == $past(lit_left_reg) - RUN_W'(1))
        else $error("literal run count did not step down by one");

    // Closing a frame clears the position and row counters.
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.frame_done |=> pos_reg == '0 && rows_reg == '0)
        else $error("counters not cleared after frame end");

    // The core never issues a result without consuming a word.
    a_res_take: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> take)
        else $error("result issued without consuming a word");

endmodule

/* hw/rtl/srld_out_stage.sv */
// ----------------------------------------------------------------------------
// Sprite RLE output stage
// Holds one decoded result and presents it on the result stream.
// ----------------------------------------------------------------------------
module srld_out_stage
    import srld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        res_valid,
    input  result_t     res,
    output logic        out_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready  = !valid_reg || m_tready;
    assign valid_next = res_valid || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, res_reg.overflow, res_reg.pixel_value,
                       res_reg.run_length, res_reg.position};
    assign m_tlast  = res_reg.frame_done;
    assign m_tuser  = res_reg.kind;

endmodule

/* hw/rtl/sprite_rle_line_decoder.sv */
// ----------------------------------------------------------------------------
// Sprite RLE line decoder
// Decodes run-length coded 16-bit sprite rows into pixel, fill and row-end
// results that carry the frame pixel position.
// ----------------------------------------------------------------------------
// Path: a word accepted into the input register is decoded by the core and
// its result is loaded into the result register, which drives m_tvalid; the
// core waits while a held result is not taken; an odd tag yields no result.
// Throughput: one word per cycle while results are taken; the row state update
// is combinational adds and compares between the input and result registers.
// Reset: aresetn low at a clock edge clears both stages and the counters and
// sets the frame height to one row.
// ----------------------------------------------------------------------------
module sprite_rle_line_decoder
    import srld_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Frame height register write port.
    input  logic                cfg_wr_en,
    input  logic [HEIGHT_W-1:0] cfg_wr_data,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,   // word[15:0]
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    // position[19:0], run_length[34:20], pixel_value[50:35], overflow[51],
    // zero padding[55:52]
    output logic [55:0]         m_tdata,
    output logic                m_tlast,   // frame_done
    output logic [1:0]          m_tuser    // kind[1:0]
);

    in_item_t item;
    result_t  res;
    logic     take;
    logic     res_valid;
    logic     out_ready;

    // The input register takes a new request in any cycle in which its held
    // word moves on, so the stream runs at full rate while the result side
    // keeps taking results.
    srld_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .item     (item)
    );

    // The core decides what the held word means: a literal pixel while a
    // literal run is pending, otherwise a tag (row end, fill, or the start of
    // a literal run, which produces no result of its own).
    srld_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .out_ready   (out_ready),
        .take        (take),
        .res_valid   (res_valid),
        .res         (res)
    );

    // The result register parts the two sides: it refills in the same cycle
    // in which its result is taken.
    srld_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Only a row end may close a frame.
    a_done_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_ROW_END)
        else $error("frame end flagged on a non row-end result");

    // A row end carries no length, colour or overflow.
    a_row_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ROW_END |-> m_tdata[51:20] == '0)
        else $error("row-end result carries payload");

    // A literal pixel never reports a fill length.
    a_literal_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_LITERAL |-> m_tdata[34:20] == '0)
        else $error("literal result carries a run length");

endmodule
